### hdl/trm_pkg.sv
// trm_pkg: shared types and codes for the typed range map table
// no dependencies; imported by trm_engine and typed_range_map_table_top
package trm_pkg;

  localparam int WORD_W = 64;
  localparam int KIND_W = 4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_EXPAND,
    OP_READ,
    OP_LIMIT
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_BAD_RANGE,
    ST_NO_ROOM,
    ST_NOT_FOUND
  } status_t;

  // byte address of the usable type register
  localparam logic [2:0] REG_USABLE_ADDR = 3'd0;

  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] size;
    logic [KIND_W-1:0] kind;
  } ent_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] length;
    logic [KIND_W-1:0] region_type;
    logic [6:0]        index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] result_address;
    logic [WORD_W-1:0] entry_base;
    logic [WORD_W-1:0] entry_length;
    logic [KIND_W-1:0] entry_type;
    logic [7:0]        entry_count;
  } res_t;

endpackage

### hdl/trm_ifs.sv
// trm_in_if / trm_out_if: valid-ready channels for requests and results
// no dependencies
interface trm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] base;
  logic [63:0] length;
  logic [3:0]  region_type;
  logic [6:0]  index;

  modport source (output valid, op, base, length, region_type, index, input ready);
  modport sink (input valid, op, base, length, region_type, index, output ready);
endinterface

interface trm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] result_address;
  logic [63:0] entry_base;
  logic [63:0] entry_length;
  logic [3:0]  entry_type;
  logic [7:0]  entry_count;

  modport source (output valid, status, result_address, entry_base, entry_length,
                  entry_type, entry_count, input ready);
  modport sink (input valid, status, result_address, entry_base, entry_length,
                entry_type, entry_count, output ready);
endinterface

### hdl/trm_engine.sv
// trm_engine: sequencer, double-banked range memory and one shared 64-bit adder
// depends on trm_pkg
module trm_engine import trm_pkg::*; #(
  parameter int MAP_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  input  logic [KIND_W-1:0] usable_type,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int VC_W  = $clog2(MAP_ENTRIES + 1);
  localparam int M_W   = $clog2(MAP_ENTRIES + 3);
  localparam int MEM_D = 2 * (2 ** IDX_W);

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_CHK, S_A_RD, S_A_EXT, S_A_PIECE, S_A_MERGE, S_FLUSH,
    S_X_RD, S_X_CUR, S_X_NXT, S_X_PRV, S_X_PRV2, S_X_SUB,
    S_R_RD, S_R_DAT, S_L_RD, S_L_CHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_NEW,
    PH_TAIL
  } phase_t;

  state_t state_r;
  phase_t ph_r;

  ent_t map_mem_r [MEM_D];
  ent_t rd_data_r;
  logic [IDX_W:0] mem_ra;
  logic [IDX_W:0] mem_wa;
  logic           mem_we;

  logic              bank_r;
  logic [VC_W-1:0]   vc_r;
  logic [VC_W-1:0]   i_r;
  logic [VC_W-1:0]   ip1;
  logic [VC_W-1:0]   im1;
  logic [M_W-1:0]    m_r;

  op_t               op_r;
  logic [WORD_W-1:0] base_r;
  logic [WORD_W-1:0] len_r;
  logic [WORD_W-1:0] end_r;
  logic [KIND_W-1:0] kind_r;
  logic [6:0]        idx_r;

  logic [WORD_W-1:0] ent_start_r;
  logic [WORD_W-1:0] e_r;
  logic [KIND_W-1:0] ent_kind_r;
  logic [WORD_W-1:0] cur_start_r;
  logic [WORD_W-1:0] cur_end_r;

  logic [WORD_W-1:0] pc_start_r;
  logic [WORD_W-1:0] pc_size_r;
  logic [WORD_W-1:0] pc_end_r;
  logic [KIND_W-1:0] pc_kind_r;
  logic [WORD_W-1:0] pnd_start_r;
  logic [WORD_W-1:0] pnd_size_r;
  logic [WORD_W-1:0] pnd_end_r;
  logic [KIND_W-1:0] pnd_kind_r;

  status_t           st_r;
  logic [WORD_W-1:0] addr_r;
  logic [WORD_W-1:0] eb_r;
  logic [WORD_W-1:0] el_r;
  logic [KIND_W-1:0] et_r;

  logic [WORD_W-1:0] alu_a;
  logic [WORD_W-1:0] alu_b;
  logic              alu_sub;
  logic [WORD_W:0]   alu_y;

  logic [WORD_W-1:0] head_end;
  logic [WORD_W-1:0] tail_start;
  logic              mergeable;
  logic              pnd_fits;
  logic              idx_ok;

  assign ip1        = i_r + 1'b1;
  assign im1        = i_r - 1'b1;
  assign head_end   = (e_r < base_r) ? e_r : base_r;
  assign tail_start = (ent_start_r > end_r) ? ent_start_r : end_r;
  assign mergeable  = (m_r != '0) && (pnd_end_r == pc_start_r) && (pnd_kind_r == pc_kind_r);
  assign pnd_fits   = (m_r != '0) && (32'(m_r) <= MAP_ENTRIES);
  assign idx_ok     = (32'(idx_r) < 32'(vc_r)) && (32'(idx_r) < MAP_ENTRIES);

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_ADD_CHK: begin
        alu_a = base_r;
        alu_b = len_r;
      end
      S_A_EXT, S_X_CUR, S_X_PRV, S_L_CHK: begin
        alu_a = rd_data_r.start;
        alu_b = rd_data_r.size;
      end
      S_A_PIECE: begin
        alu_sub = 1'b1;
        if (ph_r == PH_HEAD) begin
          alu_a = head_end;
          alu_b = ent_start_r;
        end else begin
          alu_a = e_r;
          alu_b = tail_start;
        end
      end
      S_A_MERGE: begin
        alu_a = pnd_size_r;
        alu_b = pc_size_r;
      end
      S_X_SUB: begin
        alu_sub = 1'b1;
        alu_a   = cur_start_r;
        alu_b   = len_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (WORD_W + 1)'(alu_sub);

  // memory read address: current bank, position chosen by state
  always_comb begin
    mem_ra = {bank_r, i_r[IDX_W-1:0]};
    case (state_r)
      S_X_CUR: begin
        mem_ra = (ip1 < vc_r) ? {bank_r, ip1[IDX_W-1:0]} : {bank_r, im1[IDX_W-1:0]};
      end
      S_X_NXT, S_L_RD: begin
        mem_ra = {bank_r, im1[IDX_W-1:0]};
      end
      S_R_RD: begin
        mem_ra = {bank_r, IDX_W'(idx_r)};
      end
      default: begin
        mem_ra = {bank_r, i_r[IDX_W-1:0]};
      end
    endcase
  end

  // pending merged entry goes to the scratch bank
  assign mem_we = pnd_fits && (((state_r == S_A_MERGE) && !mergeable) || (state_r == S_FLUSH));
  assign mem_wa = {~bank_r, IDX_W'(m_r - 1'b1)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem_r[mem_wa] <= '{start: pnd_start_r, size: pnd_size_r, kind: pnd_kind_r};
    end
    rd_data_r <= map_mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vc_r    <= '0;
      bank_r  <= 1'b0;
      ph_r    <= PH_HEAD;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            op_r   <= req.op;
            base_r <= req.base;
            len_r  <= req.length;
            kind_r <= req.region_type;
            idx_r  <= req.index;
            st_r   <= ST_OK;
            addr_r <= '0;
            eb_r   <= '0;
            el_r   <= '0;
            et_r   <= '0;
            i_r    <= '0;
            case (req.op)
              OP_ADD:    state_r <= S_ADD_CHK;
              OP_EXPAND: state_r <= S_X_RD;
              OP_READ:   state_r <= S_R_RD;
              OP_LIMIT: begin
                i_r     <= vc_r;
                state_r <= S_L_RD;
              end
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_ADD_CHK: begin
          end_r <= alu_y[WORD_W-1:0];
          // zero length or end at or past the top of the address space
          if (len_r == '0 || alu_y[WORD_W]) begin
            st_r    <= ST_BAD_RANGE;
            state_r <= S_DONE;
          end else begin
            ph_r    <= PH_HEAD;
            i_r     <= '0;
            m_r     <= '0;
            state_r <= S_A_RD;
          end
        end
        S_A_RD: begin
          if (ph_r == PH_NEW) begin
            pc_start_r <= base_r;
            pc_size_r  <= len_r;
            pc_end_r   <= end_r;
            pc_kind_r  <= kind_r;
            state_r    <= S_A_MERGE;
          end else if (i_r < vc_r) begin
            state_r <= S_A_EXT;
          end else if (ph_r == PH_HEAD) begin
            ph_r <= PH_NEW;
          end else begin
            state_r <= S_FLUSH;
          end
        end
        S_A_EXT: begin
          ent_start_r <= rd_data_r.start;
          ent_kind_r  <= rd_data_r.kind;
          e_r         <= alu_y[WORD_W-1:0];
          state_r     <= S_A_PIECE;
        end
        S_A_PIECE: begin
          pc_size_r <= alu_y[WORD_W-1:0];
          pc_kind_r <= ent_kind_r;
          if (ph_r == PH_HEAD && ent_start_r < base_r) begin
            pc_start_r <= ent_start_r;
            pc_end_r   <= head_end;
            state_r    <= S_A_MERGE;
          end else if (ph_r == PH_TAIL && e_r > end_r) begin
            pc_start_r <= tail_start;
            pc_end_r   <= e_r;
            state_r    <= S_A_MERGE;
          end else begin
            i_r     <= ip1;
            state_r <= S_A_RD;
          end
        end
        S_A_MERGE: begin
          if (mergeable) begin
            pnd_size_r <= alu_y[WORD_W-1:0];
            pnd_end_r  <= pc_end_r;
          end else begin
            pnd_start_r <= pc_start_r;
            pnd_size_r  <= pc_size_r;
            pnd_end_r   <= pc_end_r;
            pnd_kind_r  <= pc_kind_r;
            m_r         <= m_r + 1'b1;
          end
          if (ph_r == PH_NEW) begin
            ph_r <= PH_TAIL;
            i_r  <= '0;
          end else begin
            i_r <= ip1;
          end
          state_r <= S_A_RD;
        end
        S_FLUSH: begin
          if (32'(m_r) > MAP_ENTRIES) begin
            st_r <= ST_FULL;
          end else begin
            vc_r   <= VC_W'(m_r);
            bank_r <= ~bank_r;
            if (op_r == OP_EXPAND) begin
              addr_r <= base_r;
            end
          end
          state_r <= S_DONE;
        end
        S_X_RD: begin
          if (i_r < vc_r) begin
            state_r <= S_X_CUR;
          end else begin
            st_r    <= ST_NO_ROOM;
            state_r <= S_DONE;
          end
        end
        S_X_CUR: begin
          cur_start_r <= rd_data_r.start;
          cur_end_r   <= alu_y[WORD_W-1:0];
          if (rd_data_r.kind != kind_r) begin
            i_r     <= ip1;
            state_r <= S_X_RD;
          end else if (ip1 < vc_r) begin
            state_r <= S_X_NXT;
          end else if (i_r != '0) begin
            state_r <= S_X_PRV;
          end else begin
            i_r     <= ip1;
            state_r <= S_X_RD;
          end
        end
        S_X_NXT: begin
          if (rd_data_r.start == cur_end_r && rd_data_r.kind == usable_type) begin
            base_r  <= rd_data_r.start;
            state_r <= S_ADD_CHK;
          end else if (i_r != '0) begin
            state_r <= S_X_PRV;
          end else begin
            i_r     <= ip1;
            state_r <= S_X_RD;
          end
        end
        S_X_PRV: begin
          e_r        <= alu_y[WORD_W-1:0];
          ent_kind_r <= rd_data_r.kind;
          state_r    <= S_X_PRV2;
        end
        S_X_PRV2: begin
          if (e_r == cur_start_r && ent_kind_r == usable_type) begin
            state_r <= S_X_SUB;
          end else begin
            i_r     <= ip1;
            state_r <= S_X_RD;
          end
        end
        S_X_SUB: begin
          base_r  <= alu_y[WORD_W-1:0];
          state_r <= S_ADD_CHK;
        end
        S_R_RD: begin
          if (idx_ok) begin
            state_r <= S_R_DAT;
          end else begin
            st_r    <= ST_NOT_FOUND;
            state_r <= S_DONE;
          end
        end
        S_R_DAT: begin
          eb_r    <= rd_data_r.start;
          el_r    <= rd_data_r.size;
          et_r    <= rd_data_r.kind;
          state_r <= S_DONE;
        end
        S_L_RD: begin
          if (i_r == '0) begin
            st_r    <= ST_NOT_FOUND;
            state_r <= S_DONE;
          end else begin
            i_r     <= im1;
            state_r <= S_L_CHK;
          end
        end
        S_L_CHK: begin
          if (rd_data_r.kind == usable_type) begin
            addr_r  <= alu_y[WORD_W-1:0];
            state_r <= S_DONE;
          end else begin
            state_r <= S_L_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res = '{status: st_r, result_address: addr_r, entry_base: eb_r,
                 entry_length: el_r, entry_type: et_r, entry_count: 8'(vc_r)};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(vc_r) <= MAP_ENTRIES)
    else $error("entry count above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready right after an accepted request");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && 32'(m_r) > MAP_ENTRIES) |=> $stable(vc_r))
    else $error("count changed on a full table");
`endif

endmodule

### hdl/typed_range_map_table_top.sv
// typed_range_map_table_top: channels, usable-type register and result register
// depends on trm_pkg, trm_ifs (trm_in_if, trm_out_if) and trm_engine
//
//   channel   direction  handshake                 payload
//   in_ch     in         valid/ready               op, base, length, region_type, index
//   out_ch    out        valid/ready               status, result_address, entry_*
//   cfg       in         apb psel/penable/pready   usable_type at byte address 0
//
// one request at a time; a result register lets the next request in while
// the previous result waits.
// add: two walks of the table, each entry through the single 64-bit adder and
// one memory read port. expand: a search of the entries, then an add. limit:
// a walk back from the last entry.
// reset clears the entry count and control state; the range memory is not cleared.
module typed_range_map_table_top import trm_pkg::*; #(
  parameter int MAP_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  trm_in_if.sink      in_ch,
  trm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [KIND_W-1:0] usable_r;
  logic              reg_hit;
  req_t              req;
  logic              eng_ready;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  assign reg_hit = (paddr == REG_USABLE_ADDR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(usable_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= 4'd1;
    end else if (psel && penable && pwrite && reg_hit) begin
      usable_r <= pwdata[KIND_W-1:0];
    end
  end

  assign req = '{op: op_t'(in_ch.op), base: in_ch.base, length: in_ch.length,
                 region_type: in_ch.region_type, index: in_ch.index};
  assign in_ch.ready = eng_ready;

  trm_engine #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_ch.valid),
    .req_ready   (eng_ready),
    .req         (req),
    .usable_type (usable_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // result register between the engine and the result channel
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.result_address = out_r.result_address;
  assign out_ch.entry_base     = out_r.entry_base;
  assign out_ch.entry_length   = out_r.entry_length;
  assign out_ch.entry_type     = out_r.entry_type;
  assign out_ch.entry_count    = out_r.entry_count;

endmodule

### dv/testbench.sv
// testbench: self-checking bench for typed_range_map_table_top
// depends on trm_pkg, trm_ifs and the block's rtl; holds its own table model
`timescale 1ns / 1ps

module testbench;
  import trm_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int WORK_DEPTH = TABLE_DEPTH + 2;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // keeps the predicted range table and the results still owed by the block
  class range_map_board;
    logic [63:0] tbl_start[TABLE_DEPTH];
    logic [63:0] tbl_size[TABLE_DEPTH];
    logic [3:0]  tbl_kind[TABLE_DEPTH];
    int          tbl_count;
    logic [3:0]  ram_kind;
    res_t        owed[$];
    int          errors;
    int          accepted;

    function new();
      tbl_count = 0;
      ram_kind = 4'd1;
      errors = 0;
      accepted = 0;
    endfunction

    function status_t insert_range(logic [63:0] b, logic [63:0] len, logic [3:0] k);
      logic [63:0] ws[WORK_DEPTH];
      logic [63:0] wl[WORK_DEPTH];
      logic [3:0]  wk[WORK_DEPTH];
      logic [63:0] fin, s, e, ns;
      int n, m;
      fin = b + len;
      if (fin <= b) return ST_BAD_RANGE;
      n = 0;
      for (int i = 0; i < tbl_count; i++) begin
        s = tbl_start[i];
        e = s + tbl_size[i];
        if (s < b) begin
          ws[n] = s; wl[n] = ((e < b) ? e : b) - s; wk[n] = tbl_kind[i]; n++;
        end
      end
      ws[n] = b; wl[n] = len; wk[n] = k; n++;
      for (int i = 0; i < tbl_count; i++) begin
        s = tbl_start[i];
        e = s + tbl_size[i];
        if (e > fin && n < WORK_DEPTH) begin
          ns = (s > fin) ? s : fin;
          ws[n] = ns; wl[n] = e - ns; wk[n] = tbl_kind[i]; n++;
        end
      end
      m = 0;
      for (int i = 0; i < n; i++) begin
        if (m > 0 && ws[m-1] + wl[m-1] == ws[i] && wk[m-1] == wk[i]) begin
          wl[m-1] += wl[i];
        end else begin
          ws[m] = ws[i]; wl[m] = wl[i]; wk[m] = wk[i]; m++;
        end
      end
      if (m > TABLE_DEPTH) return ST_FULL;
      for (int i = 0; i < m; i++) begin
        tbl_start[i] = ws[i]; tbl_size[i] = wl[i]; tbl_kind[i] = wk[i];
      end
      tbl_count = m;
      return ST_OK;
    endfunction

    function void note_request(req_t rq);
      res_t r;
      logic [63:0] pick;
      bit hit;
      r = '0;
      r.status = ST_OK;
      accepted++;
      case (rq.op)
        OP_ADD: begin
          r.status = insert_range(rq.base, rq.length, rq.region_type);
        end
        OP_EXPAND: begin
          hit = 0;
          for (int i = 0; i < tbl_count && !hit; i++) begin
            if (tbl_kind[i] != rq.region_type) continue;
            if (i + 1 < tbl_count && tbl_start[i+1] == tbl_start[i] + tbl_size[i] &&
                tbl_kind[i+1] == ram_kind) begin
              pick = tbl_start[i+1]; hit = 1;
            end else if (i > 0 && tbl_start[i-1] + tbl_size[i-1] == tbl_start[i] &&
                         tbl_kind[i-1] == ram_kind) begin
              pick = tbl_start[i] - rq.length; hit = 1;
            end
          end
          if (!hit) begin
            r.status = ST_NO_ROOM;
          end else begin
            r.status = insert_range(pick, rq.length, rq.region_type);
            if (r.status == ST_OK) r.result_address = pick;
          end
        end
        OP_READ: begin
          if (rq.index < tbl_count) begin
            r.entry_base = tbl_start[rq.index];
            r.entry_length = tbl_size[rq.index];
            r.entry_type = tbl_kind[rq.index];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: begin
          r.status = ST_NOT_FOUND;
          for (int i = tbl_count - 1; i >= 0; i--) begin
            if (tbl_kind[i] == ram_kind) begin
              r.result_address = tbl_start[i] + tbl_size[i];
              r.status = ST_OK;
              break;
            end
          end
        end
      endcase
      r.entry_count = tbl_count[7:0];
      owed.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.result_address !== want.result_address) begin
        $display("%0t: result_address expected %h got %h", $time,
                 want.result_address, got.result_address);
        errors++;
      end
      if (got.entry_base !== want.entry_base) begin
        $display("%0t: entry_base expected %h got %h", $time, want.entry_base,
                 got.entry_base);
        errors++;
      end
      if (got.entry_length !== want.entry_length) begin
        $display("%0t: entry_length expected %h got %h", $time, want.entry_length,
                 got.entry_length);
        errors++;
      end
      if (got.entry_type !== want.entry_type) begin
        $display("%0t: entry_type expected %0d got %0d", $time, want.entry_type,
                 got.entry_type);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trm_in_if  in_ch ();
  trm_out_if out_ch ();

  range_map_board board = new();
  bit quiet = 0;
  bit long_hold_done = 0;

  always #5 clk = ~clk;

  typed_range_map_table_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.base = '0;
    in_ch.length = '0;
    in_ch.region_type = '0;
    in_ch.index = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = status_t'(out_ch.status);
      got.result_address = out_ch.result_address;
      got.entry_base = out_ch.entry_base;
      got.entry_length = out_ch.entry_length;
      got.entry_type = out_ch.entry_type;
      got.entry_count = out_ch.entry_count;
      board.check_result(got);
    end
  end

  // result side: random stalls, one long hold once the run is under way
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && !long_hold_done && board.accepted >= 300) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk);
        long_hold_done = 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(op_t op, logic [63:0] b, logic [63:0] len,
                              logic [3:0] k, logic [6:0] idx);
    req_t rq;
    rq.op = op; rq.base = b; rq.length = len; rq.region_type = k; rq.index = idx;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.base <= b;
    in_ch.length <= len;
    in_ch.region_type <= k;
    in_ch.index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(rq);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_usable(logic [3:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_USABLE_ADDR; pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.ram_kind = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return 64'($urandom_range(0, 511)) << 12;
    if (r < 95) return {$urandom, $urandom};
    return ALL_ONES - 64'($urandom_range(0, 65535));
  endfunction

  function automatic logic [63:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return 64'($urandom_range(1, 3)) << 12;
    if (r < 93) return {$urandom, $urandom};
    if (r < 96) return '0;
    if (r < 98) return 64'($urandom_range(64, 256)) << 12;
    return ALL_ONES;
  endfunction

  task automatic random_request();
    int r;
    logic [6:0] idx;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_request(OP_ADD, pick_base(), pick_length(), 4'($urandom_range(0, 3)), 7'($urandom));
    end else if (r < 52) begin
      send_request(OP_ADD, pick_base(), pick_length(), 4'($urandom), 7'($urandom));
    end else if (r < 67) begin
      send_request(OP_EXPAND, {$urandom, $urandom}, pick_length(),
                   4'($urandom_range(0, 3)), 7'($urandom));
    end else if (r < 85) begin
      if ($urandom_range(0, 1) == 0 && board.tbl_count > 0)
        idx = 7'($urandom_range(0, board.tbl_count - 1));
      else
        idx = 7'($urandom);
      send_request(OP_READ, {$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom), idx);
    end else begin
      send_request(OP_LIMIT, {$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom),
                   7'($urandom));
    end
  endtask

  initial begin
    logic [3:0] settings[5];
    settings = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd3};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table cases, bad ranges at the top of the address space
    send_request(OP_LIMIT, '0, '0, 4'd0, 7'd0);
    send_request(OP_READ, '0, '0, 4'd0, 7'd0);
    send_request(OP_EXPAND, '0, 64'h1000, 4'd1, 7'd0);
    send_request(OP_ADD, '0, '0, 4'd1, 7'd0);
    send_request(OP_ADD, ALL_ONES, 64'd1, 4'd1, 7'd0);
    send_request(OP_ADD, ALL_ONES, ALL_ONES, 4'd1, 7'd0);
    send_request(OP_ADD, ALL_ONES - 1, 64'd1, 4'd15, 7'd127);
    // splits at both ends, and a start that lies in a gap
    send_request(OP_ADD, 64'h1000, 64'h1000, 4'd1, 7'd0);
    send_request(OP_ADD, 64'h2000, 64'h1000, 4'd5, 7'd0);
    send_request(OP_ADD, 64'h3000, 64'h1000, 4'd1, 7'd0);
    send_request(OP_ADD, 64'h1800, 64'h1000, 4'd0, 7'd0);
    send_request(OP_ADD, 64'h0, 64'h800, 4'd2, 7'd0);
    send_request(OP_ADD, 64'h5000, 64'h1000, 4'd3, 7'd0);
    send_request(OP_EXPAND, '0, 64'h400, 4'd5, 7'd0);
    send_request(OP_EXPAND, '0, '0, 4'd5, 7'd0);
    send_request(OP_READ, '0, '0, 4'd0, 7'd0);
    send_request(OP_READ, '0, '0, 4'd0, 7'd3);
    send_request(OP_READ, '0, '0, 4'd0, 7'd127);
    send_request(OP_LIMIT, '0, '0, 4'd0, 7'd0);
    // growth that would go below address zero
    send_request(OP_ADD, 64'hF000, 64'h1000, 4'd1, 7'd0);
    send_request(OP_ADD, 64'h10000, 64'h1000, 4'd9, 7'd0);
    send_request(OP_EXPAND, '0, 64'h20000, 4'd9, 7'd0);
    send_request(OP_ADD, '0, ALL_ONES, 4'd0, 7'd0);
    send_request(OP_LIMIT, '0, '0, 4'd0, 7'd0);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_usable(settings[p]);
      if (p == 4) quiet = 1;
      for (int i = 0; i < 200; i++) begin
        if (p == 1 && i == 100) drain();
        if (!quiet && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 16));
        random_request();
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
